@@ design/kalman_position_estimator_2d_assert.svh @@
// Assertion macros for the 2D position estimator.
// Used by the top level only; needs clk and rst in scope.
`ifndef KALMAN_POSITION_ESTIMATOR_2D_ASSERT_SVH
`define KALMAN_POSITION_ESTIMATOR_2D_ASSERT_SVH

// same-cycle implication
`define KPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kpe check failed");

// next-cycle implication
`define KPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kpe check failed");

`endif

@@ design/kpe_pkg.sv @@
// Shared types, constants and saturation helper for the 2D position estimator.
// No dependencies.
package kpe_pkg;

  localparam int ST_W       = 48;   // stored state width
  localparam int AW         = 100;  // product accumulator width
  localparam int HW         = 24;   // half operand, multiplier slice
  localparam int NOISE_FRAC = 16;
  localparam int COV_INIT   = 100;

  localparam logic [1:0] REG_NOISE_XX = 2'd0;
  localparam logic [1:0] REG_NOISE_XY = 2'd1;
  localparam logic [1:0] REG_NOISE_YX = 2'd2;
  localparam logic [1:0] REG_NOISE_YY = 2'd3;

  typedef logic signed [ST_W-1:0] st_t;
  typedef logic signed [AW-1:0]   acc_t;

  typedef struct packed {
    logic start;
    logic clear;  // zero the accumulator first
    logic neg;    // subtract the product
  } mac_ctl_t;

  localparam st_t  ST_MAX     = {1'b0, {(ST_W-1){1'b1}}};
  localparam st_t  ST_MIN     = {1'b1, {(ST_W-1){1'b0}}};
  localparam acc_t ACC_ST_MAX = acc_t'(ST_MAX);
  localparam acc_t ACC_ST_MIN = acc_t'(ST_MIN);

  function automatic st_t sat_acc(input acc_t v);
    st_t r;
    if (v > ACC_ST_MAX) r = ST_MAX;
    else if (v < ACC_ST_MIN) r = ST_MIN;
    else r = v[ST_W-1:0];
    return r;
  endfunction

endpackage

@@ design/kalman_position_estimator_2d.sv @@
// 2D position Kalman filter with identity model, one shared MAC and divider.
// Per transaction: setup (predict, innovation), then 11 dot products, each of two MAC
// passes plus a post step, with four gain divides, one after each gain product, then
// output. A singular S stops after the determinant. One transaction at a time: ready
// only while idle. Output waits on a held result. Reset (sync, rst high): belief zero,
// covariance diag 100, R = I.
`include "kalman_position_estimator_2d_assert.svh"

module kalman_position_estimator_2d import kpe_pkg::*; #(
  parameter int POS_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // perceived_x, perceived_y, dest_x, dest_y, measured_x, measured_y
  input  logic [((6*POS_BITS+7)/8)*8-1:0]      s_tdata,
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // estimate_x, estimate_y
  output logic [((2*POS_BITS+7)/8)*8-1:0]      m_tdata,
  // singular
  output logic                                 m_tuser,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int OUT_W = ((2*POS_BITS+7)/8)*8;
  localparam int NW    = AW + FRAC_BITS + 2;
  localparam int DW    = AW + 1;
  localparam int NSH   = (FRAC_BITS < NOISE_FRAC) ? NOISE_FRAC - FRAC_BITS : 1;
  localparam acc_t POS_MAX = (acc_t'(1) <<< (POS_BITS-1)) - acc_t'(1);
  localparam acc_t POS_MIN = -POS_MAX - acc_t'(1);
  localparam logic [NW-1:0] K_LIM = NW'(1) << (ST_W-1);
  localparam st_t COV_RST = st_t'(COV_INIT) <<< FRAC_BITS;

  // job codes: one two-term dot product each
  localparam logic [3:0] JOB_DET   = 4'd0;
  localparam logic [3:0] JOB_GAIN0 = 4'd1;
  localparam logic [3:0] JOB_GAIN1 = 4'd2;
  localparam logic [3:0] JOB_GAIN2 = 4'd3;
  localparam logic [3:0] JOB_GAIN3 = 4'd4;
  localparam logic [3:0] JOB_BEL0  = 4'd5;
  localparam logic [3:0] JOB_BEL1  = 4'd6;
  localparam logic [3:0] JOB_COV0  = 4'd7;
  localparam logic [3:0] JOB_COV1  = 4'd8;
  localparam logic [3:0] JOB_COV2  = 4'd9;
  localparam logic [3:0] JOB_COV3  = 4'd10;

  typedef enum logic [3:0] {
    S_IDLE, S_PRED, S_INNOV, S_MUL_GO, S_MUL_WAIT, S_POST,
    S_DIV_GO, S_DIV_WAIT, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [30:0]        noise_xx;
  logic signed [31:0] noise_xy;
  logic signed [31:0] noise_yx;
  logic [30:0]        noise_yy;

  // filter state and scratch
  st_t belief [2];
  st_t cov    [4];
  st_t pred   [2];
  st_t innov  [2];
  st_t s_m    [4];
  st_t k_m    [4];
  st_t ncov   [3];
  logic signed [POS_BITS-1:0] in_per [2];
  logic signed [POS_BITS-1:0] in_dst [2];
  logic signed [POS_BITS-1:0] in_mea [2];

  logic [3:0]    job;
  logic          term;
  logic          sing;
  logic          det_neg;
  logic          k_neg;
  logic [AW-1:0] det_abs;
  logic [AW-1:0] n_abs;

  // shared units
  mac_ctl_t      mac_ctl;
  st_t           op_a;
  st_t           op_b;
  logic          mac_busy;
  acc_t          acc;
  logic          div_start;
  logic          div_busy;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic [NW-1:0] quo;

  logic [3:0] gidx;
  logic [3:0] cidx;
  logic [3:0] bidx;
  st_t        rf;
  st_t        k_sat;
  acc_t       nf [4];
  logic [POS_BITS-1:0] est [2];

  // ---------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------
  // right shift by n, rounding half away from zero
  function automatic acc_t rsh_rnd(input acc_t v, input int unsigned n);
    logic [AW-1:0] m;
    m = v[AW-1] ? -v : v;
    m = (m + (AW'(1) << (n-1))) >> n;
    return v[AW-1] ? -acc_t'(m) : acc_t'(m);
  endfunction

  // Q16.16 noise into the internal fraction
  function automatic acc_t to_frac(input acc_t v);
    acc_t r;
    if (FRAC_BITS >= NOISE_FRAC) r = v <<< (FRAC_BITS - NOISE_FRAC);
    else r = rsh_rnd(v, NSH);
    return r;
  endfunction

  always_comb begin
    nf[0] = to_frac(acc_t'({1'b0, noise_xx}));
    nf[1] = to_frac(acc_t'(noise_xy));
    nf[2] = to_frac(acc_t'(noise_yx));
    nf[3] = to_frac(acc_t'({1'b0, noise_yy}));
  end

  // ---------------------------------------------------------------------
  // APB register file; writes land only while idle by contract
  // ---------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_xx <= 31'd65536;
      noise_xy <= '0;
      noise_yx <= '0;
      noise_yy <= 31'd65536;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_NOISE_XX: noise_xx <= pwdata[30:0];
        REG_NOISE_XY: noise_xy <= pwdata;
        REG_NOISE_YX: noise_yx <= pwdata;
        REG_NOISE_YY: noise_yy <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NOISE_XX: prdata = {1'b0, noise_xx};
      REG_NOISE_XY: prdata = noise_xy;
      REG_NOISE_YX: prdata = noise_yx;
      REG_NOISE_YY: prdata = {1'b0, noise_yy};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // operand select for the shared MAC
  //   det:    s00*s11 - s01*s10
  //   gain:   P row times adjugate column (adjugate signs via neg flag)
  //   belief: K row times innovation
  //   cov:    P row times K column
  // ---------------------------------------------------------------------
  assign gidx = job - JOB_GAIN0;
  assign bidx = job - JOB_BEL0;
  assign cidx = job - JOB_COV0;

  always_comb begin
    op_a          = s_m[0];
    op_b          = s_m[3];
    mac_ctl.start = (state == S_MUL_GO);
    mac_ctl.clear = !term;
    mac_ctl.neg   = 1'b0;
    case (job)
      JOB_DET: begin
        op_a        = term ? s_m[1] : s_m[0];
        op_b        = term ? s_m[2] : s_m[3];
        mac_ctl.neg = term;
      end
      JOB_GAIN0, JOB_GAIN1, JOB_GAIN2, JOB_GAIN3: begin
        op_a = cov[{gidx[1], term}];
        if (!term) begin
          op_b        = gidx[0] ? s_m[1] : s_m[3];
          mac_ctl.neg = gidx[0];
        end else begin
          op_b        = gidx[0] ? s_m[0] : s_m[2];
          mac_ctl.neg = !gidx[0];
        end
      end
      JOB_BEL0, JOB_BEL1: begin
        op_a = k_m[{bidx[0], term}];
        op_b = innov[term];
      end
      JOB_COV0, JOB_COV1, JOB_COV2, JOB_COV3: begin
        op_a = cov[{cidx[1], term}];
        op_b = k_m[{term, cidx[0]}];
      end
      default: ;
    endcase
  end

  kpe_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (op_a),
    .b    (op_b),
    .busy (mac_busy),
    .acc  (acc)
  );

  // gain = round(n * 2^F / det): (2*|n|*2^F + |det|) / (2*|det|)
  assign div_start = (state == S_DIV_GO);
  assign div_num   = (NW'(n_abs) << (FRAC_BITS+1)) + NW'(det_abs);
  assign div_den   = {det_abs, 1'b0};

  kpe_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  // product back to FRAC_BITS, half away from zero, saturated
  assign rf = sat_acc(rsh_rnd(acc, FRAC_BITS));

  always_comb begin
    if (k_neg) k_sat = (quo > K_LIM) ? ST_MIN : -st_t'(quo[ST_W-1:0]);
    else k_sat = (quo >= K_LIM) ? ST_MAX : st_t'(quo[ST_W-1:0]);
  end

  // estimate rounding and clamp to the position range
  always_comb begin
    acc_t rb;
    for (int i = 0; i < 2; i++) begin
      rb = rsh_rnd(acc_t'(belief[i]), FRAC_BITS);
      if (rb > POS_MAX) rb = POS_MAX;
      else if (rb < POS_MIN) rb = POS_MIN;
      est[i] = rb[POS_BITS-1:0];
    end
  end

  assign s_tready = (state == S_IDLE);

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      belief[0] <= '0;
      belief[1] <= '0;
      cov[0]    <= COV_RST;
      cov[1]    <= '0;
      cov[2]    <= '0;
      cov[3]    <= COV_RST;
      job       <= JOB_DET;
      term      <= 1'b0;
      sing      <= 1'b0;
    end else begin
      // the output state reloads the result register itself
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < 2; i++) begin
              in_per[i] <= s_tdata[i*POS_BITS +: POS_BITS];
              in_dst[i] <= s_tdata[(2+i)*POS_BITS +: POS_BITS];
              in_mea[i] <= s_tdata[(4+i)*POS_BITS +: POS_BITS];
            end
            sing  <= 1'b0;
            state <= S_PRED;
          end
        end
        S_PRED: begin
          for (int i = 0; i < 2; i++)
            pred[i] <= sat_acc(acc_t'(belief[i]) +
                               ((acc_t'(in_dst[i]) - acc_t'(in_per[i])) <<< FRAC_BITS));
          for (int i = 0; i < 4; i++)
            s_m[i] <= sat_acc(acc_t'(cov[i]) + nf[i]);
          state <= S_INNOV;
        end
        S_INNOV: begin
          for (int i = 0; i < 2; i++)
            innov[i] <= sat_acc((acc_t'(in_mea[i]) <<< FRAC_BITS) - acc_t'(pred[i]));
          job   <= JOB_DET;
          term  <= 1'b0;
          state <= S_MUL_GO;
        end
        S_MUL_GO: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (!mac_busy) begin
            if (!term) begin
              term  <= 1'b1;
              state <= S_MUL_GO;
            end else begin
              state <= S_POST;
            end
          end
        end
        S_POST: begin
          term <= 1'b0;
          if (job == JOB_DET) begin
            if (acc == '0) begin
              // singular: keep state, report the unchanged belief
              sing  <= 1'b1;
              state <= S_OUT;
            end else begin
              det_neg <= acc[AW-1];
              det_abs <= acc[AW-1] ? -acc : acc;
              job     <= JOB_GAIN0;
              state   <= S_MUL_GO;
            end
          end else if (job <= JOB_GAIN3) begin
            n_abs <= acc[AW-1] ? -acc : acc;
            k_neg <= acc[AW-1] ^ det_neg;
            state <= S_DIV_GO;
          end else if (job <= JOB_BEL1) begin
            belief[bidx[0]] <= sat_acc(acc_t'(pred[bidx[0]]) + acc_t'(rf));
            job   <= job + 4'd1;
            state <= S_MUL_GO;
          end else if (job < JOB_COV3) begin
            ncov[cidx[1:0]] <= sat_acc(acc_t'(cov[cidx[1:0]]) - acc_t'(rf));
            job   <= job + 4'd1;
            state <= S_MUL_GO;
          end else begin
            cov[0] <= ncov[0];
            cov[1] <= ncov[1];
            cov[2] <= ncov[2];
            cov[3] <= sat_acc(acc_t'(cov[3]) - acc_t'(rf));
            state  <= S_OUT;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!div_busy) begin
            k_m[gidx[1:0]] <= k_sat;
            job   <= job + 4'd1;
            state <= S_MUL_GO;
          end
        end
        S_OUT: begin
          // result register frees as soon as the previous one is taken
          if (!m_tvalid || m_tready) begin
            m_tdata  <= OUT_W'({est[1], est[0]});
            m_tuser  <= sing;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `KPE_ASSERT_NOW(a_accept_idle, s_tvalid && s_tready, state == S_IDLE)
  `KPE_ASSERT_NOW(a_mac_free, mac_ctl.start, !mac_busy && !div_busy)
  `KPE_ASSERT_NOW(a_units_exclusive, div_busy, !mac_busy)
  `KPE_ASSERT_NEXT(a_sing_keeps_cov, state == S_POST && job == JOB_DET && acc == '0, cov[0] == $past(cov[0]) && cov[3] == $past(cov[3]))

endmodule

@@ design/kpe_mac.sv @@
// Shared multiply-accumulate: signed 48x48 product built from four 24x24
// partial products, one per cycle. Depends on kpe_pkg.
module kpe_mac import kpe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mac_ctl_t ctl,
  input  st_t      a,
  input  st_t      b,
  output logic     busy,
  output acc_t     acc
);

  logic [ST_W-1:0] ma;
  logic [ST_W-1:0] mb;
  logic            sub;
  logic [1:0]      step;
  logic [HW-1:0]   a_sl;
  logic [HW-1:0]   b_sl;
  logic [2*HW-1:0] pp;
  logic [AW-1:0]   term;

  always_comb begin
    a_sl = step[0] ? ma[2*HW-1:HW] : ma[HW-1:0];
    b_sl = step[1] ? mb[2*HW-1:HW] : mb[HW-1:0];
    pp   = a_sl * b_sl;
    case (step)
      2'd0:    term = AW'(pp);
      2'd3:    term = AW'(pp) << (2*HW);
      default: term = AW'(pp) << HW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (ctl.start) begin
      ma   <= a[ST_W-1] ? (~a + 1'b1) : a;
      mb   <= b[ST_W-1] ? (~b + 1'b1) : b;
      sub  <= a[ST_W-1] ^ b[ST_W-1] ^ ctl.neg;
      busy <= 1'b1;
      step <= 2'd0;
      if (ctl.clear) acc <= '0;
    end else if (busy) begin
      acc  <= sub ? (acc - acc_t'(term)) : (acc + acc_t'(term));
      step <= step + 2'd1;
      if (step == 2'd3) busy <= 1'b0;
    end
  end

endmodule

@@ design/kpe_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on kpe_pkg only through the import convention.
module kpe_div import kpe_pkg::*; #(
  parameter int NW = 118,
  parameter int DW = 101
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic [DW:0]   r_sh;
  logic          fits;

  always_comb begin
    r_sh = {rem, quo[NW-1]};
    fits = (r_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      quo  <= num;
      dsr  <= den;
      rem  <= '0;
      cnt  <= CW'(NW-1);
      busy <= 1'b1;
    end else if (busy) begin
      rem <= fits ? DW'(r_sh - {1'b0, dsr}) : r_sh[DW-1:0];
      quo <= {quo[NW-2:0], fits};
      if (cnt == '0) busy <= 1'b0;
      else cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ bench/tb_kalman_position_estimator_2d.sv @@
// Self-checking bench for the 2D position estimator: streams items, writes the
// noise registers over APB and checks every estimate. Depends on kpe_pkg and the RTL.
module tb_kalman_position_estimator_2d import kpe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [15:0] per_x, per_y, dst_x, dst_y, mea_x, mea_y;
  } pos_item_t;

  typedef struct {
    logic signed [15:0] est_x, est_y;
    logic               sing;
  } estimate_t;

  localparam longint S48_MAX = (64'sd1 <<< 47) - 1;
  localparam longint S48_MIN = -(64'sd1 <<< 47);

  // Estimator twin plus the queue of estimates still owed by the block.
  class estimate_board;
    longint    belief[2];
    longint    cov[4];
    longint    rnoise[4];
    estimate_t owed[$];
    int        errors, checked, singulars;

    function new();
      belief = '{0, 0};
      cov    = '{100 * 65536, 0, 0, 100 * 65536};
      rnoise = '{65536, 0, 0, 65536};
    endfunction

    function longint sat48(wide_t v);
      if (v > wide_t'(S48_MAX)) return S48_MAX;
      if (v < wide_t'(S48_MIN)) return S48_MIN;
      return longint'(v);
    endfunction

    // drop FRAC bits, half away from zero, then clamp to 48 bits
    function longint round_frac(wide_t v);
      wide_t m;
      m = (v < 0) ? -v : v;
      m = (m + 32768) >>> 16;
      return sat48((v < 0) ? -m : m);
    endfunction

    function logic signed [15:0] to_pos(longint b);
      longint m, v;
      m = (b < 0) ? -b : b;
      m = (m + 32768) >>> 16;
      v = (b < 0) ? -m : m;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void set_noise(int idx, logic [31:0] val);
      if (idx == REG_NOISE_XX || idx == REG_NOISE_YY) rnoise[idx] = longint'({1'b0, val[30:0]});
      else rnoise[idx] = longint'($signed(val));
    endfunction

    function void note_item(pos_item_t it);
      longint pred[2], innov[2], s[4], adj[4], k[4], nb[2], nc[4];
      longint per[2], dst[2], mea[2];
      wide_t  det, ad, n, q, c;
      estimate_t e;
      per = '{it.per_x, it.per_y};
      dst = '{it.dst_x, it.dst_y};
      mea = '{it.mea_x, it.mea_y};
      for (int i = 0; i < 2; i++) begin
        pred[i]  = sat48(wide_t'(belief[i]) + wide_t'((dst[i] - per[i]) * 65536));
        innov[i] = sat48(wide_t'(mea[i] * 65536) - wide_t'(pred[i]));
      end
      for (int i = 0; i < 4; i++) s[i] = sat48(wide_t'(cov[i]) + wide_t'(rnoise[i]));
      det = wide_t'(s[0]) * wide_t'(s[3]) - wide_t'(s[1]) * wide_t'(s[2]);
      e.sing = (det == 0);
      if (!e.sing) begin
        adj = '{s[3], -s[1], -s[2], s[0]};
        ad  = (det < 0) ? -det : det;
        for (int i = 0; i < 2; i++)
          for (int j = 0; j < 2; j++) begin
            n = wide_t'(cov[i*2]) * wide_t'(adj[j]) + wide_t'(cov[i*2+1]) * wide_t'(adj[2+j]);
            q = (n < 0) ? -n : n;
            q = ((q <<< 17) + ad) / (ad <<< 1);
            k[i*2+j] = sat48(((n < 0) != (det < 0)) ? -q : q);
          end
        for (int i = 0; i < 2; i++) begin
          c = wide_t'(k[i*2]) * wide_t'(innov[0]) + wide_t'(k[i*2+1]) * wide_t'(innov[1]);
          nb[i] = sat48(wide_t'(pred[i]) + wide_t'(round_frac(c)));
        end
        for (int i = 0; i < 2; i++)
          for (int j = 0; j < 2; j++) begin
            c = wide_t'(cov[i*2]) * wide_t'(k[j]) + wide_t'(cov[i*2+1]) * wide_t'(k[2+j]);
            nc[i*2+j] = sat48(wide_t'(cov[i*2+j]) - wide_t'(round_frac(c)));
          end
        belief = nb;
        cov    = nc;
      end
      e.est_x = to_pos(belief[0]);
      e.est_y = to_pos(belief[1]);
      owed.push_back(e);
    endfunction

    function void check_estimate(estimate_t got);
      estimate_t e;
      if (owed.size() == 0) begin
        $error("unexpected estimate x=%0d y=%0d singular=%0b", got.est_x, got.est_y, got.sing);
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      if (got.sing) singulars++;
      if (got.est_x !== e.est_x) begin
        $error("estimate_x: expected %0d, got %0d", e.est_x, got.est_x); errors++;
      end
      if (got.est_y !== e.est_y) begin
        $error("estimate_y: expected %0d, got %0d", e.est_y, got.est_y); errors++;
      end
      if (got.sing !== e.sing) begin
        $error("singular: expected %0b, got %0b", e.sing, got.sing); errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
  logic [95:0] s_tdata;   // perceived_x, perceived_y, dest_x, dest_y, measured_x, measured_y
  logic [31:0] m_tdata;   // estimate_x, estimate_y
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  kalman_position_estimator_2d u_top (.*);

  estimate_board board = new();
  int  send_idle_pct, recv_idle_pct;
  bit  recv_hold;
  int  quiet_cycles, items_sent;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // receiver: random stalls, or a long hold-off to back the block up
  always @(negedge clk) begin
    if (rst || recv_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_estimate('{est_x: m_tdata[15:0], est_y: m_tdata[31:16], sing: m_tuser});
  end

  // watchdog: any transaction on either stream or APB resets the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_noise(idx, val);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_item(pos_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.mea_y, it.mea_x, it.dst_y, it.dst_x, it.per_y, it.per_x};
    do @(posedge clk); while (!s_tready);
    board.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // wait for every owed estimate, then let the block go quiet before APB
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.owed.size() != 0) @(negedge clk);
    repeat (700) @(negedge clk);
  endtask

  function automatic pos_item_t rand_item();
    pos_item_t it;
    if ($urandom_range(3) == 0) begin
      {it.per_x, it.per_y, it.dst_x, it.dst_y} = {$urandom, $urandom};
      {it.mea_x, it.mea_y} = $urandom;
    end else begin
      // plausible motion: small step, measurement close to the destination
      it.per_x = 16'($signed($urandom_range(4000)) - 2000);
      it.per_y = 16'($signed($urandom_range(4000)) - 2000);
      it.dst_x = 16'(it.per_x + $signed($urandom_range(60)) - 30);
      it.dst_y = 16'(it.per_y + $signed($urandom_range(60)) - 30);
      it.mea_x = 16'(it.dst_x + $signed($urandom_range(8)) - 4);
      it.mea_y = 16'(it.dst_y + $signed($urandom_range(8)) - 4);
    end
    return it;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_item(rand_item());
  endtask

  initial begin
    logic signed [15:0] ext[4];
    longint c;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 36; recv_idle_pct = 74; recv_hold = 1'b0;
    items_sent = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed: field extremes at reset noise
    ext = '{16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1};
    for (int i = 0; i < 4; i++)
      send_item('{ext[i], ext[3-i], ext[3-i], ext[i], ext[i], ext[(i+1)%4]});
    send_item('{16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000, 16'sh7FFF});
    send_item('{-16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000});
    send_item('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_item('{16'sd10, 16'sd20, 16'sd11, 16'sd19, 16'sd12, 16'sd18});
    drain();

    // singular innovation covariance: R chosen so every entry of S is equal
    c = (board.cov[0] > board.cov[3]) ? board.cov[0] : board.cov[3];
    apb_write(REG_NOISE_XX, 32'(c - board.cov[0]));
    apb_write(REG_NOISE_XY, 32'(c - board.cov[1]));
    apb_write(REG_NOISE_YX, 32'(c - board.cov[2]));
    apb_write(REG_NOISE_YY, 32'(c - board.cov[3]));
    repeat (6) send_item(rand_item());
    drain();

    // all-zero noise; long receiver hold-off while items keep coming
    apb_write(REG_NOISE_XX, 32'd0);
    apb_write(REG_NOISE_XY, 32'd0);
    apb_write(REG_NOISE_YX, 32'd0);
    apb_write(REG_NOISE_YY, 32'd0);
    fork
      begin
        @(posedge clk) recv_hold = 1'b1;
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
      end
    join_none
    run_random(150);
    drain();

    // noise at its extremes
    send_idle_pct = 74; recv_idle_pct = 36;
    apb_write(REG_NOISE_XX, 32'h7FFF_FFFF);
    apb_write(REG_NOISE_XY, 32'h8000_0000);
    apb_write(REG_NOISE_YX, 32'h7FFF_FFFF);
    apb_write(REG_NOISE_YY, 32'hFFFF_FFFF);
    run_random(150);
    drain();

    // random noise settings
    for (int ph = 0; ph < 3; ph++) begin
      apb_write(REG_NOISE_XX, $urandom);
      apb_write(REG_NOISE_XY, $urandom);
      apb_write(REG_NOISE_YX, $urandom);
      apb_write(REG_NOISE_YY, $urandom);
      run_random(120);
      drain();
    end

    // back to unit diagonal noise with small cross terms, no idling
    send_idle_pct = 0; recv_idle_pct = 0;
    apb_write(REG_NOISE_XX, 32'h0001_0000);
    apb_write(REG_NOISE_XY, 32'h0000_4000);
    apb_write(REG_NOISE_YX, 32'hFFFF_C000);
    apb_write(REG_NOISE_YY, 32'h0001_0000);
    run_random(400);
    drain();

    $display("Sent %0d position items over 8 noise settings; %0d estimates checked, %0d singular.",
             items_sent, board.checked, board.singulars);
    if (board.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
